@@ design/shst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shst_pkg
// types and constants shared by the scoped hash symbol table
// ----------------------------------------------------------------------------
package shst_pkg;

  localparam int KeyBits    = 32;
  localparam int ValueBits  = 32;
  localparam int KindBits   = 2;
  localparam int StatusBits = 3;
  localparam int KeyBytes   = KeyBits / 8;

  localparam int DefBucketCount = 127;
  localparam int DefPoolDepth   = 256;

  typedef enum logic [KindBits-1:0] {
    KIND_ENTER = 2'd0,
    KIND_LOOK  = 2'd1,
    KIND_POP   = 2'd2
  } kind_t;

  typedef enum logic [StatusBits-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ZERO_KEY  = 3'd4
  } status_t;

endpackage

@@ design/shst_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shst_if
// request and result channels of the scoped hash symbol table
// ----------------------------------------------------------------------------
interface shst_in_if;
  logic                             valid;
  logic                             ready;
  logic [shst_pkg::KindBits-1:0]    kind;
  logic [shst_pkg::KeyBits-1:0]     key;
  logic [shst_pkg::ValueBits-1:0]   value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface shst_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [shst_pkg::ValueBits-1:0]   result_value;
  logic [shst_pkg::KeyBits-1:0]     popped_key;
  logic [shst_pkg::StatusBits-1:0]  status;

  modport source (output valid, found, result_value, popped_key, status, input ready);
  modport sink   (input valid, found, result_value, popped_key, status, output ready);
endinterface

@@ design/shst_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shst_hash
// key mod bucket count, one key byte per cycle through residue tables
// ----------------------------------------------------------------------------
module shst_hash #(
  parameter int BUCKET_COUNT = shst_pkg::DefBucketCount
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [shst_pkg::KeyBits-1:0]      key,
  output logic                              done,
  output logic [$clog2(BUCKET_COUNT)-1:0]   bucket
);

  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int PW = (shst_pkg::KeyBytes > 1) ? $clog2(shst_pkg::KeyBytes) : 1;

  logic [BW-1:0] tbl [shst_pkg::KeyBytes][256];

  for (genvar p = 0; p < shst_pkg::KeyBytes; p++) begin : g_pos
    for (genvar d = 0; d < 256; d++) begin : g_dig
      localparam longint unsigned Res =
        ((unsigned'(longint'(d)) << (8 * p)) % BUCKET_COUNT);
      assign tbl[p][d] = Res[BW-1:0];
    end
  end

  logic                         busy_r;
  logic                         done_r;
  logic [PW-1:0]                pos_r;
  logic [shst_pkg::KeyBits-1:0] key_r;
  logic [BW-1:0]                acc_r;
  logic [BW:0]                  sum;
  logic [BW-1:0]                acc_nxt;

  always_comb begin
    sum = {1'b0, acc_r} + {1'b0, tbl[pos_r][key_r[7:0]]};
    if (sum >= (BW+1)'(BUCKET_COUNT)) begin
      acc_nxt = BW'(sum - (BW+1)'(BUCKET_COUNT));
    end else begin
      acc_nxt = sum[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pos_r  <= '0;
        key_r  <= key;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        key_r <= key_r >> 8;
        pos_r <= pos_r + PW'(1);
        if (pos_r == PW'(shst_pkg::KeyBytes - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign bucket = acc_r;

endmodule

@@ design/shst_heads.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shst_heads
// bucket head memory with a clearing sweep after reset
// ----------------------------------------------------------------------------
module shst_heads #(
  parameter int BUCKET_COUNT = shst_pkg::DefBucketCount,
  parameter int LINK_W       = 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              re,
  input  logic [$clog2(BUCKET_COUNT)-1:0]   raddr,
  output logic [LINK_W-1:0]                 rdata,
  input  logic                              we,
  input  logic [$clog2(BUCKET_COUNT)-1:0]   waddr,
  input  logic [LINK_W-1:0]                 wdata,
  output logic                              clearing
);

  localparam int BW = $clog2(BUCKET_COUNT);

  logic [LINK_W-1:0] mem [BUCKET_COUNT];
  logic [LINK_W-1:0] rdata_r;
  logic              clr_busy_r;
  logic [BW-1:0]     clr_idx_r;
  logic              wr_en;
  logic [BW-1:0]     wr_addr;
  logic [LINK_W-1:0] wr_data;

  always_comb begin
    wr_en   = clr_busy_r | we;
    wr_addr = clr_busy_r ? clr_idx_r : waddr;
    wr_data = clr_busy_r ? '0 : wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + BW'(1);
      if (clr_idx_r == BW'(BUCKET_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata    = rdata_r;
  assign clearing = clr_busy_r;

endmodule

@@ design/shst_pool.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shst_pool
// stack-ordered binding pool: key, value and chain link per entry
// ----------------------------------------------------------------------------
module shst_pool #(
  parameter int POOL_DEPTH = shst_pkg::DefPoolDepth,
  parameter int LINK_W     = 9
) (
  input  logic                              clk,
  input  logic                              re,
  input  logic [$clog2(POOL_DEPTH)-1:0]     raddr,
  output logic [shst_pkg::KeyBits-1:0]      rkey,
  output logic [shst_pkg::ValueBits-1:0]    rvalue,
  output logic [LINK_W-1:0]                 rnext,
  input  logic                              we,
  input  logic [$clog2(POOL_DEPTH)-1:0]     waddr,
  input  logic [shst_pkg::KeyBits-1:0]      wkey,
  input  logic [shst_pkg::ValueBits-1:0]    wvalue,
  input  logic [LINK_W-1:0]                 wnext
);

  localparam int EW = shst_pkg::KeyBits + shst_pkg::ValueBits + LINK_W;

  logic [EW-1:0] mem [POOL_DEPTH];
  logic [EW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wkey, wvalue, wnext};
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign {rkey, rvalue, rnext} = rdata_r;

endmodule

@@ design/scoped_hash_symbol_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scoped_hash_symbol_table_unit
// scoped symbol table: hashed bucket chains over a stack-ordered binding pool
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the bucket heads are swept to
// empty, one per cycle, so in_bus.ready first rises once the sweep is done.
// The key hash takes one key byte per cycle (four bytes), then the bucket head
// is read for an enter or a look. A look then reads the pool once per chain
// link visited. A pop first reads the top entry of the pool and hashes its
// key, and skips the head read. Rejected requests (zero key, full pool, empty
// pop, unused kind) skip the hash and go straight to the result. A new request
// is accepted the cycle after the previous result is placed in the output
// register, even if that result has not yet been taken.
// ----------------------------------------------------------------------------
module scoped_hash_symbol_table_unit #(
  parameter int BUCKET_COUNT = shst_pkg::DefBucketCount,
  parameter int POOL_DEPTH   = shst_pkg::DefPoolDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  shst_in_if.sink     in_bus,
  shst_out_if.source  out_bus
);

  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int AW = $clog2(POOL_DEPTH);
  localparam int LW = $clog2(POOL_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP_RD,
    S_HASH,
    S_HEAD,
    S_CMP,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [shst_pkg::KindBits-1:0]   kind_r, kind_nxt;
  logic [shst_pkg::KeyBits-1:0]    key_r, key_nxt;
  logic [shst_pkg::ValueBits-1:0]  value_r, value_nxt;
  logic [LW-1:0]                   used_r, used_nxt;
  logic [LW-1:0]                   steps_r, steps_nxt;
  logic [LW-1:0]                   next_r, next_nxt;
  logic                            found_r, found_nxt;
  logic [shst_pkg::ValueBits-1:0]  rval_r, rval_nxt;
  logic [shst_pkg::KeyBits-1:0]    pkey_r, pkey_nxt;
  shst_pkg::status_t               status_r, status_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [shst_pkg::ValueBits-1:0]  out_rval_r, out_rval_nxt;
  logic [shst_pkg::KeyBits-1:0]    out_pkey_r, out_pkey_nxt;
  shst_pkg::status_t               out_status_r, out_status_nxt;

  logic                            hash_start;
  logic [shst_pkg::KeyBits-1:0]    hash_key;
  logic                            hash_done;
  logic [BW-1:0]                   bucket;

  logic                            head_re, head_we, head_clearing;
  logic [LW-1:0]                   head_rdata, head_wdata;

  logic                            pool_re, pool_we;
  logic [AW-1:0]                   pool_raddr;
  logic [shst_pkg::KeyBits-1:0]    pool_rkey;
  logic [shst_pkg::ValueBits-1:0]  pool_rvalue;
  logic [LW-1:0]                   pool_rnext;

  logic                            accept;
  logic [LW-1:0]                   walk_link;

  shst_hash #(.BUCKET_COUNT(BUCKET_COUNT)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key    (hash_key),
    .done   (hash_done),
    .bucket (bucket)
  );

  shst_heads #(.BUCKET_COUNT(BUCKET_COUNT), .LINK_W(LW)) u_heads (
    .clk      (clk),
    .rst_n    (rst_n),
    .re       (head_re),
    .raddr    (bucket),
    .rdata    (head_rdata),
    .we       (head_we),
    .waddr    (bucket),
    .wdata    (head_wdata),
    .clearing (head_clearing)
  );

  shst_pool #(.POOL_DEPTH(POOL_DEPTH), .LINK_W(LW)) u_pool (
    .clk    (clk),
    .re     (pool_re),
    .raddr  (pool_raddr),
    .rkey   (pool_rkey),
    .rvalue (pool_rvalue),
    .rnext  (pool_rnext),
    .we     (pool_we),
    .waddr  (used_r[AW-1:0]),
    .wkey   (key_r),
    .wvalue (value_r),
    .wnext  (head_rdata)
  );

  assign in_bus.ready = (state_r == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign walk_link    = (state_r == S_HEAD) ? head_rdata : pool_rnext;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    used_nxt       = used_r;
    steps_nxt      = steps_r;
    next_nxt       = next_r;
    found_nxt      = found_r;
    rval_nxt       = rval_r;
    pkey_nxt       = pkey_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_found_nxt  = out_found_r;
    out_rval_nxt   = out_rval_r;
    out_pkey_nxt   = out_pkey_r;
    out_status_nxt = out_status_r;
    hash_start     = 1'b0;
    hash_key       = in_bus.key;
    head_re        = 1'b0;
    head_we        = 1'b0;
    head_wdata     = used_r + LW'(1);
    pool_re        = 1'b0;
    pool_we        = 1'b0;
    pool_raddr     = AW'(used_r - LW'(1));

    case (state_r)
      S_CLEAR: begin
        if (!head_clearing) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          kind_nxt   = in_bus.kind;
          key_nxt    = in_bus.key;
          value_nxt  = in_bus.value;
          steps_nxt  = '0;
          found_nxt  = 1'b0;
          rval_nxt   = '0;
          pkey_nxt   = '0;
          status_nxt = shst_pkg::ST_OK;
          state_nxt  = S_DONE;
          case (in_bus.kind)
            shst_pkg::KIND_ENTER: begin
              if (in_bus.key == '0) begin
                status_nxt = shst_pkg::ST_ZERO_KEY;
              end else if (used_r == LW'(POOL_DEPTH)) begin
                status_nxt = shst_pkg::ST_FULL;
              end else begin
                hash_start = 1'b1;
                state_nxt  = S_HASH;
              end
            end
            shst_pkg::KIND_LOOK: begin
              if (in_bus.key == '0) begin
                status_nxt = shst_pkg::ST_ZERO_KEY;
              end else begin
                hash_start = 1'b1;
                state_nxt  = S_HASH;
              end
            end
            shst_pkg::KIND_POP: begin
              if (used_r == '0) begin
                status_nxt = shst_pkg::ST_EMPTY;
              end else begin
                pool_re   = 1'b1;
                state_nxt = S_POP_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_POP_RD: begin
        pkey_nxt   = pool_rkey;
        next_nxt   = pool_rnext;
        hash_key   = pool_rkey;
        hash_start = 1'b1;
        state_nxt  = S_HASH;
      end

      S_HASH: begin
        if (hash_done) begin
          if (kind_r == shst_pkg::KIND_POP) begin
            head_we    = 1'b1;
            head_wdata = next_r;
            used_nxt   = used_r - LW'(1);
            state_nxt  = S_DONE;
          end else begin
            head_re   = 1'b1;
            state_nxt = S_HEAD;
          end
        end
      end

      S_HEAD, S_CMP: begin
        if (state_r == S_HEAD && kind_r == shst_pkg::KIND_ENTER) begin
          pool_we   = 1'b1;
          head_we   = 1'b1;
          used_nxt  = used_r + LW'(1);
          state_nxt = S_DONE;
        end else if (state_r == S_CMP && pool_rkey == key_r) begin
          found_nxt = 1'b1;
          rval_nxt  = pool_rvalue;
          state_nxt = S_DONE;
        end else if (walk_link == '0 || steps_r == LW'(POOL_DEPTH)) begin
          status_nxt = shst_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          pool_re    = 1'b1;
          pool_raddr = AW'(walk_link - LW'(1));
          steps_nxt  = steps_r + LW'(1);
          state_nxt  = S_CMP;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = found_r;
          out_rval_nxt   = rval_r;
          out_pkey_nxt   = pkey_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kind_r       <= kind_nxt;
      key_r        <= key_nxt;
      value_r      <= value_nxt;
      used_r       <= used_nxt;
      steps_r      <= steps_nxt;
      next_r       <= next_nxt;
      found_r      <= found_nxt;
      rval_r       <= rval_nxt;
      pkey_r       <= pkey_nxt;
      status_r     <= status_nxt;
      out_valid_r  <= out_valid_nxt;
      out_found_r  <= out_found_nxt;
      out_rval_r   <= out_rval_nxt;
      out_pkey_r   <= out_pkey_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.found        = out_found_r;
  assign out_bus.result_value = out_rval_r;
  assign out_bus.popped_key   = out_pkey_r;
  assign out_bus.status       = out_status_r;

endmodule

@@ design/shst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shst_checker
// port-level checks of the scoped hash symbol table, bound to the top level
// ----------------------------------------------------------------------------
module shst_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_found,
  input logic [shst_pkg::ValueBits-1:0]    out_result_value,
  input logic [shst_pkg::KeyBits-1:0]      out_popped_key,
  input logic [shst_pkg::StatusBits-1:0]   out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_result_value) && $stable(out_popped_key))
    else $error("result beat changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("request taken during bucket clear");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= shst_pkg::ST_ZERO_KEY)
    else $error("undefined status code");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == shst_pkg::ST_OK &&
      out_popped_key == '0)
    else $error("found beat with bad status or popped key");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != shst_pkg::ST_OK |->
      !out_found && out_result_value == '0 && out_popped_key == '0)
    else $error("error beat carries data");

endmodule

bind scoped_hash_symbol_table_unit shst_checker u_shst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_bus.valid),
  .in_ready         (in_bus.ready),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_found        (out_bus.found),
  .out_result_value (out_bus.result_value),
  .out_popped_key   (out_bus.popped_key),
  .out_status       (out_bus.status)
);

@@ tb/scoped_hash_symbol_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scoped_hash_symbol_table_checker
// Watches the request and result channels of the symbol table. Every
// accepted request is run through a local copy of the bucket heads and the
// binding pool, and the reply that it should produce is queued. Each result
// beat is compared field by field with the oldest queued reply.
// ----------------------------------------------------------------------------
module scoped_hash_symbol_table_checker
  import shst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  shst_in_if          in_mon,
  shst_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  localparam int unsigned Buckets = DefBucketCount;
  localparam int unsigned Depth   = DefPoolDepth;

  typedef struct packed {
    logic                 found;
    logic [ValueBits-1:0] result_value;
    logic [KeyBits-1:0]   popped_key;
    status_t              status;
  } table_reply_t;

  logic [8:0]           head_link [Buckets];
  logic [KeyBits-1:0]   bind_key  [Depth];
  logic [ValueBits-1:0] bind_val  [Depth];
  logic [8:0]           bind_next [Depth];
  int unsigned          live_count;

  table_reply_t expected_replies [$];

  function automatic table_reply_t resolve_request(logic [KindBits-1:0] kind,
                                                   logic [KeyBits-1:0] key,
                                                   logic [ValueBits-1:0] value);
    table_reply_t reply;
    logic [8:0]   link;
    int unsigned  bucket;
    int unsigned  idx;
    bit           hit;
    reply = '0;
    reply.status = ST_OK;
    hit = 1'b0;
    case (kind)
      KIND_ENTER: begin
        if (key == '0) begin
          reply.status = ST_ZERO_KEY;
        end else if (live_count >= Depth) begin
          reply.status = ST_FULL;
        end else begin
          bucket = key % Buckets;
          bind_key[live_count]  = key;
          bind_val[live_count]  = value;
          bind_next[live_count] = head_link[bucket];
          head_link[bucket]     = 9'(live_count + 1);
          live_count++;
        end
      end
      KIND_LOOK: begin
        if (key == '0) begin
          reply.status = ST_ZERO_KEY;
        end else begin
          reply.status = ST_NOT_FOUND;
          link = head_link[key % Buckets];
          for (int steps = 0; steps < Depth && link != '0 && !hit; steps++) begin
            idx = int'(link) - 1;
            if (bind_key[idx] == key) begin
              hit = 1'b1;
              reply.found = 1'b1;
              reply.result_value = bind_val[idx];
              reply.status = ST_OK;
            end else begin
              link = bind_next[idx];
            end
          end
        end
      end
      KIND_POP: begin
        if (live_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          idx = live_count - 1;
          head_link[bind_key[idx] % Buckets] = bind_next[idx];
          reply.popped_key = bind_key[idx];
          live_count = idx;
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    live_count = 0;
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      for (int b = 0; b < Buckets; b++) begin
        head_link[b] = '0;
      end
      live_count = 0;
      expected_replies.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_replies.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, actual found=%b value=%h key=%h status=%0d",
                   $time, out_mon.found, out_mon.result_value, out_mon.popped_key,
                   out_mon.status);
        end else begin
          want = expected_replies.pop_front();
          if (out_mon.found !== want.found)
            note_mismatch("found", 32'(want.found), 32'(out_mon.found));
          if (out_mon.result_value !== want.result_value)
            note_mismatch("result_value", want.result_value, out_mon.result_value);
          if (out_mon.popped_key !== want.popped_key)
            note_mismatch("popped_key", want.popped_key, out_mon.popped_key);
          if (out_mon.status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(out_mon.status));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_replies.push_back(resolve_request(in_mon.kind, in_mon.key, in_mon.value));
      end
    end
    pending_count <= expected_replies.size();
  end

endmodule

@@ tb/scoped_hash_symbol_table_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scoped_hash_symbol_table_unit_tb
// Drives enter, look and pop requests into the symbol table: a directed
// opening on empty tables, shadowed keys and shared buckets, then random
// traffic that fills the pool past full and works it back down. Both
// channels stall at random. The checker beside the block gives the verdict.
// ----------------------------------------------------------------------------
module scoped_hash_symbol_table_unit_tb;
  import shst_pkg::*;

  localparam logic [KindBits-1:0] KindUnused = 2'd3;

  logic        clk;
  logic        rst_n;
  bit          steady;
  int unsigned fail_count;
  int unsigned pending_count;

  logic [KeyBits-1:0] live_keys [$];

  shst_in_if  in_bus ();
  shst_out_if out_bus ();

  scoped_hash_symbol_table_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  scoped_hash_symbol_table_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= steady || ($urandom_range(0, 99) >= 36);
    end
  end

  task automatic request(logic [KindBits-1:0] kind, logic [KeyBits-1:0] key,
                         logic [ValueBits-1:0] value);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.kind  <= kind;
    in_bus.key   <= key;
    in_bus.value <= value;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (kind == KIND_ENTER && key != '0 && live_keys.size() < DefPoolDepth)
      live_keys.push_back(key);
    if (kind == KIND_POP && live_keys.size() > 0)
      void'(live_keys.pop_back());
  endtask

  // live keys, keys sharing their bucket, and fresh keys
  function automatic logic [KeyBits-1:0] pick_key();
    int                 roll;
    logic [KeyBits-1:0] base;
    logic [KeyBits-1:0] mate;
    roll = $urandom_range(0, 99);
    if (live_keys.size() == 0 || roll < 20) begin
      base = $urandom();
      return (base == '0) ? 32'd1 : base;
    end
    base = live_keys[$urandom_range(0, live_keys.size() - 1)];
    if (roll < 75) return base;
    mate = base + 32'(DefBucketCount) * $urandom_range(1, 3);
    return (mate == '0) ? base : mate;
  endfunction

  task automatic random_request(int enter_pct, int look_pct, int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < enter_pct) begin
      request(KIND_ENTER, pick_key(), $urandom());
    end else if (roll < enter_pct + look_pct) begin
      request(KIND_LOOK, pick_key(), $urandom());
    end else if (roll < enter_pct + look_pct + pop_pct) begin
      request(KIND_POP, $urandom(), $urandom());
    end else begin
      case ($urandom_range(0, 2))
        0:       request(KindUnused, $urandom(), $urandom());
        1:       request(KIND_ENTER, '0, $urandom());
        default: request(KIND_LOOK, '0, $urandom());
      endcase
    end
  endtask

  task automatic wait_for_replies();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    int n;
    rst_n         = 1'b0;
    steady        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.kind   = KIND_ENTER;
    in_bus.key    = '0;
    in_bus.value  = '0;
    out_bus.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, zero keys, unused kind
    request(KIND_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    request(KIND_LOOK, 32'd5, '0);
    request(KIND_ENTER, '0, 32'hFFFF_FFFF);
    request(KIND_LOOK, '0, '0);
    request(KindUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // shared bucket and shadowed binding
    request(KIND_ENTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    request(KIND_ENTER, 32'd1, '0);
    request(KIND_ENTER, 32'd128, 32'h1234_5678);
    request(KIND_ENTER, 32'd1, 32'hA5A5_A5A5);
    request(KIND_LOOK, 32'd1, '0);
    request(KIND_LOOK, 32'd128, '0);
    request(KIND_LOOK, 32'd255, '0);
    request(KIND_LOOK, 32'hFFFF_FFFF, '0);
    request(KIND_ENTER, 32'd127, 32'd1);
    request(KIND_ENTER, 32'd126, 32'h8000_0000);
    request(KIND_POP, '0, '0);
    request(KIND_POP, '0, '0);
    request(KIND_POP, '0, '0);
    request(KIND_LOOK, 32'd1, '0);
    request(KIND_POP, '0, '0);
    request(KIND_POP, '0, '0);
    request(KIND_POP, '0, '0);
    request(KIND_POP, '0, '0);
    request(KIND_LOOK, 32'hFFFF_FFFF, '0);

    // fill the pool, then push past full
    n = 0;
    while (live_keys.size() < DefPoolDepth) begin
      if (n == 20) steady <= 1'b1;
      if (n == 110) steady <= 1'b0;
      random_request(85, 10, 2);
      n++;
    end
    repeat (4) request(KIND_ENTER, pick_key(), $urandom());
    request(KIND_LOOK, pick_key(), $urandom());
    wait_for_replies();

    repeat (100) random_request(8, 32, 55);
    repeat (60) random_request(35, 35, 25);

    wait_for_replies();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS scoped_hash_symbol_table_unit");
    end else begin
      $display("FAIL scoped_hash_symbol_table_unit");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL scoped_hash_symbol_table_unit");
    $finish;
  end

endmodule
